// ----- rtl/core/delta_list_event_scheduler_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef DELTA_LIST_EVENT_SCHEDULER_TOP_ASSERT_SVH
`define DELTA_LIST_EVENT_SCHEDULER_TOP_ASSERT_SVH

// Implication in the same cycle.
`define DLES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define DLES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dles_pkg.sv -----
package dles_pkg;

    // Item kinds
    localparam logic [2:0] KIND_ADVANCE = 3'd0;
    localparam logic [2:0] KIND_ADD     = 3'd1;
    localparam logic [2:0] KIND_SET_CMP = 3'd2;
    localparam logic [2:0] KIND_POP     = 3'd3;
    localparam logic [2:0] KIND_SKIP    = 3'd4;
    localparam logic [2:0] KIND_RESET_Q = 3'd5;

    // Event types
    localparam logic [1:0] EV_VIDEO   = 2'd0;
    localparam logic [1:0] EV_COMPARE = 2'd1;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 1;
    localparam logic [0:0]  CFG_INCREMENT = 1'd0;
    localparam logic [0:0]  CFG_VDELAY    = 1'd1;

    localparam logic [3:0]  INCREMENT_RESET = 4'd1;
    localparam logic [31:0] VDELAY_RESET    = 32'd62500;

    // One stored entry: type over a signed 33-bit delta
    localparam int ENTRY_W = 35;

    localparam logic signed [32:0] DELTA_MAX = 33'sh0_FFFF_FFFF;
    localparam logic signed [32:0] DELTA_MIN = 33'sh1_0000_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] amount;
        logic [1:0]  ev_code;
    } item_t;

    typedef struct packed {
        logic        head_due;
        logic        popped_valid;
        logic [1:0]  popped_type;
        logic [31:0] count_now;
        logic        compare_pending;
        logic [4:0]  entries_used;
        logic [1:0]  error;
    } result_t;

    // Clamp a 34-bit signed value to the 33-bit delta range
    function automatic logic signed [32:0] sat33(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = DELTA_MAX;
        lo = DELTA_MIN;
        if (v > hi)
        begin
            return DELTA_MAX;
        end
        else if (v < lo)
        begin
            return DELTA_MIN;
        end
        return v[32:0];
    endfunction

    function automatic logic signed [32:0] sub33(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [33:0] ax;
        logic signed [33:0] bx;
        ax = a;
        bx = b;
        return sat33(ax - bx);
    endfunction

    function automatic logic signed [32:0] add33(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [33:0] ax;
        logic signed [33:0] bx;
        ax = a;
        bx = b;
        return sat33(ax + bx);
    endfunction

endpackage

// ----- rtl/core/dles_ram.sv -----
module dles_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/delta_list_event_scheduler_top.sv -----
// Channel   Signals                               Direction
// item      item_valid, item_stall, item          in (stall out)
// result    result_valid, result_stall, result    out (stall in)
// config    cfg_valid, cfg_ready, cfg_index/data  in (ready out)
//
// Advance, skip, reset queue and unused kinds go straight to the done state; a pop,
// an add and a set compare may walk or shift the stored entries, with one memory
// read and one write per cycle while walking and shifting.
// After reset the queue holds one video event; no clearing pass is needed.
// A new item is taken while the previous result waits in the output register.
module delta_list_event_scheduler_top #(
    parameter int MAX_EVENTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  dles_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output dles_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dles_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);

    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int UW = $clog2(MAX_EVENTS + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INS_START = 4'd1;
    localparam logic [3:0] S_WALK_INS  = 4'd2;
    localparam logic [3:0] S_UP        = 4'd3;
    localparam logic [3:0] S_WR_HI     = 4'd4;
    localparam logic [3:0] S_WR_LO     = 4'd5;
    localparam logic [3:0] S_WALK_RC   = 4'd6;
    localparam logic [3:0] S_DOWN      = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] cmp_reg, cmp_next;
    logic        flag_reg, flag_next;
    logic [UW-1:0] used_reg, used_next;
    logic signed [32:0] head_d_reg, head_d_next;
    logic [1:0]  head_t_reg, head_t_next;
    logic [3:0]  inc_reg;
    logic [31:0] vdelay_reg;
    logic signed [32:0] rem_reg, rem_next;
    logic [1:0]  type_in_reg, type_in_next;
    logic signed [32:0] hold_d_reg, hold_d_next;
    logic [1:0]  hold_t_reg, hold_t_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic        merge_reg, merge_next;
    logic        down_pop_reg, down_pop_next;
    logic [1:0]  err_reg, err_next;
    logic        popv_reg, popv_next;
    logic [1:0]  popt_reg, popt_next;
    logic        out_valid_reg, out_valid_next;
    dles_pkg::result_t out_reg, out_next;

    // Memory port signals
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [dles_pkg::ENTRY_W-1:0] ram_wdata;
    logic [dles_pkg::ENTRY_W-1:0] ram_rdata;

    logic signed [32:0] rd_d;
    logic [1:0]         rd_t;
    logic [UW-1:0]      idx_u;
    logic [31:0]        cycles;
    logic signed [32:0] rem_step;

    logic accept;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    dles_ram #(
        .WIDTH(dles_pkg::ENTRY_W),
        .DEPTH(MAX_EVENTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_addr_next),
        .rdata(ram_rdata)
    );

    // Entry 0 lives in the head registers
    assign rd_d  = (rd_addr_reg == '0) ? head_d_reg : $signed(ram_rdata[32:0]);
    assign rd_t  = (rd_addr_reg == '0) ? head_t_reg : ram_rdata[34:33];
    assign idx_u = UW'(rd_addr_reg);
    assign cycles = 32'(item.amount * {28'd0, inc_reg});
    assign rem_step = dles_pkg::sub33(rem_reg, rd_d);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmp_next      = cmp_reg;
        flag_next     = flag_reg;
        used_next     = used_reg;
        head_d_next   = head_d_reg;
        head_t_next   = head_t_reg;
        rem_next      = rem_reg;
        type_in_next  = type_in_reg;
        hold_d_next   = hold_d_reg;
        hold_t_next   = hold_t_reg;
        pos_next      = pos_reg;
        rd_addr_next  = rd_addr_reg;
        merge_next    = merge_reg;
        down_pop_next = down_pop_reg;
        err_next      = err_reg;
        popv_next     = popv_reg;
        popt_next     = popt_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    err_next   = dles_pkg::ERR_NONE;
                    popv_next  = 1'b0;
                    popt_next  = dles_pkg::EV_VIDEO;
                    state_next = S_DONE;
                    case (item.kind)
                        dles_pkg::KIND_ADVANCE:
                        begin
                            count_next = count_reg + cycles;
                            if (used_reg != '0)
                            begin
                                head_d_next = dles_pkg::sub33(head_d_reg,
                                                              $signed({1'b0, cycles}));
                            end
                        end
                        dles_pkg::KIND_ADD:
                        begin
                            rem_next     = $signed({1'b0, item.amount});
                            type_in_next = item.ev_code;
                            state_next   = S_INS_START;
                        end
                        dles_pkg::KIND_SET_CMP:
                        begin
                            flag_next = 1'b0;
                            if (item.amount != cmp_reg)
                            begin
                                cmp_next = item.amount;
                                if (item.amount != '0)
                                begin
                                    rem_next     = $signed({1'b0, item.amount - count_reg});
                                    type_in_next = dles_pkg::EV_COMPARE;
                                    if (used_reg == '0)
                                    begin
                                        state_next = S_INS_START;
                                    end
                                    else
                                    begin
                                        rd_addr_next = '0;
                                        state_next   = S_WALK_RC;
                                    end
                                end
                            end
                        end
                        dles_pkg::KIND_POP:
                        begin
                            if (used_reg == '0)
                            begin
                                err_next = dles_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                popv_next = 1'b1;
                                popt_next = head_t_reg;
                                if (head_t_reg == dles_pkg::EV_COMPARE)
                                begin
                                    flag_next = 1'b1;
                                end
                                if (used_reg == UW'(1))
                                begin
                                    used_next = '0;
                                end
                                else
                                begin
                                    rd_addr_next  = AW'(1);
                                    merge_next    = 1'b0;
                                    down_pop_next = 1'b1;
                                    state_next    = S_DOWN;
                                end
                            end
                        end
                        dles_pkg::KIND_SKIP:
                        begin
                            if (used_reg == '0)
                            begin
                                err_next = dles_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                count_next  = count_reg + (head_d_reg[31:0] - 32'd1);
                                head_d_next = 33'sd1;
                            end
                        end
                        dles_pkg::KIND_RESET_Q:
                        begin
                            head_d_next = $signed({1'b0, vdelay_reg});
                            head_t_next = dles_pkg::EV_VIDEO;
                            used_next   = UW'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Insert: check room, then write entry 0 if the queue is empty, else walk from the head
            S_INS_START:
            begin
                if (used_reg >= UW'(MAX_EVENTS))
                begin
                    err_next   = dles_pkg::ERR_FULL;
                    state_next = S_DONE;
                end
                else if (used_reg == '0)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = '0;
                    ram_wdata   = {type_in_reg, rem_reg};
                    used_next   = UW'(1);
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_addr_next = '0;
                    state_next   = S_WALK_INS;
                end
            end

            S_WALK_INS:
            begin
                if (rem_reg <= rd_d)
                begin
                    pos_next    = rd_addr_reg;
                    hold_d_next = rd_d;
                    hold_t_next = rd_t;
                    if (idx_u + UW'(1) < used_reg)
                    begin
                        rd_addr_next = AW'(used_reg - UW'(1));
                        state_next   = S_UP;
                    end
                    else
                    begin
                        state_next = S_WR_HI;
                    end
                end
                else
                begin
                    rem_next = rem_step;
                    if (idx_u + UW'(1) == used_reg)
                    begin
                        // Goes past the tail
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(used_reg);
                        ram_wdata  = {type_in_reg, rem_step};
                        used_next  = used_reg + UW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr_next = AW'(idx_u + UW'(1));
                    end
                end
            end

            // Shift the tail up by one, highest entry first
            S_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_u + UW'(1));
                ram_wdata = {rd_t, rd_d};
                if (rd_addr_reg == AW'(UW'(pos_reg) + UW'(1)))
                begin
                    state_next = S_WR_HI;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg - AW'(1);
                end
            end

            S_WR_HI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(UW'(pos_reg) + UW'(1));
                ram_wdata  = {hold_t_reg, dles_pkg::sub33(hold_d_reg, rem_reg)};
                state_next = S_WR_LO;
            end

            S_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = {type_in_reg, rem_reg};
                used_next  = used_reg + UW'(1);
                state_next = S_DONE;
            end

            // Find the first compare event; reads run one entry ahead
            S_WALK_RC:
            begin
                rd_addr_next = AW'(idx_u + UW'(1));
                if (rd_t == dles_pkg::EV_COMPARE)
                begin
                    if (idx_u + UW'(1) < used_reg)
                    begin
                        hold_d_next   = rd_d;
                        merge_next    = 1'b1;
                        down_pop_next = 1'b0;
                        state_next    = S_DOWN;
                    end
                    else
                    begin
                        used_next  = used_reg - UW'(1);
                        state_next = S_INS_START;
                    end
                end
                else if (idx_u + UW'(1) == used_reg)
                begin
                    state_next = S_INS_START;
                end
            end

            // Shift entries down by one; first write may fold in a removed delta
            S_DOWN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = rd_addr_reg - AW'(1);
                merge_next = 1'b0;
                if (merge_reg)
                begin
                    ram_wdata = {rd_t, dles_pkg::add33(hold_d_reg, rd_d)};
                end
                else
                begin
                    ram_wdata = {rd_t, rd_d};
                end
                if (idx_u + UW'(1) < used_reg)
                begin
                    rd_addr_next = AW'(idx_u + UW'(1));
                end
                else
                begin
                    used_next  = used_reg - UW'(1);
                    state_next = down_pop_reg ? S_DONE : S_INS_START;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Head registers mirror entry 0
        if (ram_we && ram_waddr == '0)
        begin
            head_d_next = $signed(ram_wdata[32:0]);
            head_t_next = ram_wdata[34:33];
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && (!out_valid_reg || !result_stall))
        begin
            out_valid_next           = 1'b1;
            out_next.head_due        = (used_reg != '0) &&
                                       (head_d_reg[32] || head_d_reg == '0);
            out_next.popped_valid    = popv_reg;
            out_next.popped_type     = popt_reg;
            out_next.count_now       = count_reg;
            out_next.compare_pending = flag_reg;
            out_next.entries_used    = 5'(used_reg);
            out_next.error           = err_reg;
        end
    end

    // Control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_reg       <= '0;
            flag_reg      <= 1'b0;
            used_reg      <= UW'(1);
            head_d_reg    <= $signed({1'b0, dles_pkg::VDELAY_RESET});
            head_t_reg    <= dles_pkg::EV_VIDEO;
            inc_reg       <= dles_pkg::INCREMENT_RESET;
            vdelay_reg    <= dles_pkg::VDELAY_RESET;
            merge_reg     <= 1'b0;
            down_pop_reg  <= 1'b0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_reg       <= cmp_next;
            flag_reg      <= flag_next;
            used_reg      <= used_next;
            head_d_reg    <= head_d_next;
            head_t_reg    <= head_t_next;
            merge_reg     <= merge_next;
            down_pop_reg  <= down_pop_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == dles_pkg::CFG_INCREMENT)
                begin
                    inc_reg <= cfg_data[3:0];
                end
                else if (cfg_index == dles_pkg::CFG_VDELAY)
                begin
                    vdelay_reg <= cfg_data;
                end
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        type_in_reg <= type_in_next;
        hold_d_reg  <= hold_d_next;
        hold_t_reg  <= hold_t_next;
        pos_reg     <= pos_next;
        err_reg     <= err_next;
        popv_reg    <= popv_next;
        popt_reg    <= popt_next;
        out_reg     <= out_next;
    end

endmodule

// ----- rtl/core/dles_checker.sv -----
`include "delta_list_event_scheduler_top_assert.svh"

module dles_checker #(
    parameter int MAX_EVENTS = 16
) (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input dles_pkg::result_t result
);

    // Queue never reports more entries than its capacity
    `DLES_ASSERT_IMP(a_used_bound, result_valid, result.entries_used <= 5'(MAX_EVENTS), "entries over capacity")

    // No type without a pop
    `DLES_ASSERT_IMP(a_pop_type, result_valid && !result.popped_valid, result.popped_type == dles_pkg::EV_VIDEO, "popped_type without pop")

    // A pop never reports an error
    `DLES_ASSERT_IMP(a_err_code, result_valid && result.popped_valid, result.error == dles_pkg::ERR_NONE, "pop reported an error")

    // One item at a time
    `DLES_ASSERT_NXT(a_busy, item_valid && !item_stall, item_stall, "item taken while busy")

    // Stalled result holds
    `DLES_ASSERT_NXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind delta_list_event_scheduler_top dles_checker #(
    .MAX_EVENTS(MAX_EVENTS)
) u_dles_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
);

// ----- bench/tb_delta_list_event_scheduler_top.sv -----
module tb_delta_list_event_scheduler_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam longint DMAX = 64'sd4294967295;
    localparam longint DMIN = -64'sd4294967296;

    // Queue model: deltas kept as 64-bit signed, clamped to the 33-bit range
    class sched_scoreboard;
        longint     delta_q[DEPTH];
        logic [1:0] type_q[DEPTH];
        int         used;
        logic [31:0] count;
        logic [31:0] cmp_val;
        logic       cmp_flag;
        logic [3:0] incr;
        logic [31:0] vdelay;
        dles_pkg::result_t pending[$];
        int         errors;

        function new();
            incr = dles_pkg::INCREMENT_RESET;
            vdelay = dles_pkg::VDELAY_RESET;
            count = 0;
            cmp_val = 0;
            cmp_flag = 0;
            errors = 0;
            reload();
        endfunction

        function longint clamp(longint v);
            if (v > DMAX) return DMAX;
            if (v < DMIN) return DMIN;
            return v;
        endfunction

        function void reload();
            for (int i = 0; i < DEPTH; i++)
            begin
                delta_q[i] = 0;
                type_q[i] = dles_pkg::EV_VIDEO;
            end
            delta_q[0] = vdelay;
            used = 1;
        endfunction

        function bit insert(logic [31:0] delay, logic [1:0] ty);
            longint rem;
            int i;
            rem = delay;
            if (used >= DEPTH) return 0;
            for (i = 0; i < used; i++)
            begin
                if (rem <= delta_q[i])
                begin
                    delta_q[i] = clamp(delta_q[i] - rem);
                    for (int j = used; j > i; j--)
                    begin
                        delta_q[j] = delta_q[j-1];
                        type_q[j] = type_q[j-1];
                    end
                    break;
                end
                rem = clamp(rem - delta_q[i]);
            end
            delta_q[i] = rem;
            type_q[i] = ty;
            used++;
            return 1;
        endfunction

        function void drop_compare();
            for (int i = 0; i < used; i++)
            begin
                if (type_q[i] == dles_pkg::EV_COMPARE)
                begin
                    if (i + 1 < used)
                    begin
                        delta_q[i+1] = clamp(delta_q[i+1] + delta_q[i]);
                        for (int j = i; j + 1 < used; j++)
                        begin
                            delta_q[j] = delta_q[j+1];
                            type_q[j] = type_q[j+1];
                        end
                    end
                    used--;
                    return;
                end
            end
        endfunction

        function void write_reg(logic [dles_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == dles_pkg::CFG_INCREMENT) incr = data[3:0];
            else vdelay = data;
        endfunction

        // Apply one accepted item and queue the status it should produce
        function void note_item(dles_pkg::item_t it);
            dles_pkg::result_t r;
            logic [31:0] cyc;
            r = '0;
            r.error = dles_pkg::ERR_NONE;
            case (it.kind)
                dles_pkg::KIND_ADVANCE:
                begin
                    cyc = it.amount * {28'd0, incr};
                    count += cyc;
                    if (used > 0) delta_q[0] = clamp(delta_q[0] - longint'(cyc));
                end
                dles_pkg::KIND_ADD:
                    if (!insert(it.amount, it.ev_code)) r.error = dles_pkg::ERR_FULL;
                dles_pkg::KIND_SET_CMP:
                begin
                    cmp_flag = 0;
                    if (it.amount != cmp_val)
                    begin
                        if (it.amount != 0)
                        begin
                            drop_compare();
                            if (!insert(it.amount - count, dles_pkg::EV_COMPARE))
                                r.error = dles_pkg::ERR_FULL;
                        end
                        cmp_val = it.amount;
                    end
                end
                dles_pkg::KIND_POP:
                    if (used == 0) r.error = dles_pkg::ERR_EMPTY;
                    else
                    begin
                        r.popped_valid = 1;
                        r.popped_type = type_q[0];
                        for (int j = 0; j + 1 < used; j++)
                        begin
                            delta_q[j] = delta_q[j+1];
                            type_q[j] = type_q[j+1];
                        end
                        used--;
                        if (r.popped_type == dles_pkg::EV_COMPARE) cmp_flag = 1;
                    end
                dles_pkg::KIND_SKIP:
                    if (used == 0) r.error = dles_pkg::ERR_EMPTY;
                    else
                    begin
                        cyc = 32'(delta_q[0] - 1);
                        count += cyc;
                        delta_q[0] = 1;
                    end
                dles_pkg::KIND_RESET_Q:
                    reload();
                default:;
            endcase
            r.head_due = (used > 0 && delta_q[0] <= 0);
            r.count_now = count;
            r.compare_pending = cmp_flag;
            r.entries_used = 5'(used);
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(dles_pkg::result_t got);
            dles_pkg::result_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.head_due !== exp_r.head_due)
                report("head_due", exp_r.head_due, got.head_due);
            if (got.popped_valid !== exp_r.popped_valid)
                report("popped_valid", exp_r.popped_valid, got.popped_valid);
            if (got.popped_type !== exp_r.popped_type)
                report("popped_type", exp_r.popped_type, got.popped_type);
            if (got.count_now !== exp_r.count_now)
                report("count_now", exp_r.count_now, got.count_now);
            if (got.compare_pending !== exp_r.compare_pending)
                report("compare_pending", exp_r.compare_pending, got.compare_pending);
            if (got.entries_used !== exp_r.entries_used)
                report("entries_used", exp_r.entries_used, got.entries_used);
            if (got.error !== exp_r.error)
                report("error", exp_r.error, got.error);
        endfunction

        function void report(string field, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s expected %h actual %h", $realtime, field, e, a);
            errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic item_valid = 0;
    logic item_stall;
    dles_pkg::item_t item = '0;
    logic result_valid;
    logic result_stall = 0;
    dles_pkg::result_t result;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [dles_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    sched_scoreboard board;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    longint cycle_count = 0;

    always #10 clk = ~clk;

    delta_list_event_scheduler_top #(.MAX_EVENTS(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Result side: random stall, long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Valid stays up between back-to-back items; it drops only on idle cycles
    task automatic send_item(dles_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 0;
            @(negedge clk);
        end
        item_valid <= 1;
        item <= it;
        do @(posedge clk); while (item_stall);
        board.note_item(it);
        @(negedge clk);
    endtask

    task automatic send_op(logic [2:0] k, logic [31:0] a, logic [1:0] t);
        dles_pkg::item_t it;
        it.kind = k;
        it.amount = a;
        it.ev_code = t;
        send_item(it);
    endtask

    task automatic write_reg(logic [dles_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // Mostly well-formed traffic, biased so the queue fills and empties
    task automatic random_item();
        int pick;
        logic [31:0] a;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: a = $urandom;
            1: a = $urandom_range(200);
            2: a = 32'hFFFF_FFFF - $urandom_range(3);
            default: a = $urandom_range(100000);
        endcase
        if (pick < 30) send_op(dles_pkg::KIND_ADD, a, 2'($urandom));
        else if (pick < 45) send_op(dles_pkg::KIND_ADVANCE,
                                    $urandom_range(3) == 0 ? a : $urandom_range(5000),
                                    2'($urandom));
        else if (pick < 55) send_op(dles_pkg::KIND_SET_CMP, $urandom_range(4) == 0 ? 0 : a,
                                    2'($urandom));
        else if (pick < 80) send_op(dles_pkg::KIND_POP, a, 2'($urandom));
        else if (pick < 90) send_op(dles_pkg::KIND_SKIP, a, 2'($urandom));
        else if (pick < 94) send_op(dles_pkg::KIND_RESET_Q, a, 2'($urandom));
        else send_op(3'($urandom_range(7)), a, 2'($urandom));
    endtask

    initial
    begin
        board = new();
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: extremes and each special case
        send_op(dles_pkg::KIND_ADVANCE, 0, 0);
        send_op(dles_pkg::KIND_ADVANCE, 62499, 0);
        send_op(dles_pkg::KIND_ADD, 0, 2'd2);
        send_op(dles_pkg::KIND_ADD, 32'hFFFF_FFFF, 2'd3);
        send_op(dles_pkg::KIND_ADD, 1, 2'd1);
        send_op(dles_pkg::KIND_SET_CMP, 100, 0);
        send_op(dles_pkg::KIND_SET_CMP, 100, 0);
        send_op(dles_pkg::KIND_SET_CMP, 0, 0);
        send_op(dles_pkg::KIND_SET_CMP, 5, 0);
        send_op(dles_pkg::KIND_SKIP, 0, 0);
        send_op(dles_pkg::KIND_ADVANCE, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < 6; i++) send_op(dles_pkg::KIND_POP, 0, 0);
        send_op(dles_pkg::KIND_SKIP, 0, 0);
        send_op(dles_pkg::KIND_ADVANCE, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < 17; i++)
            send_op(dles_pkg::KIND_ADD, $urandom_range(50), 2'($urandom));
        send_op(dles_pkg::KIND_SET_CMP, 32'hFFFF_FFFF, 0);
        send_op(3'd6, 32'hFFFF_FFFF, 2'd3);
        send_op(3'd7, 0, 0);
        send_op(dles_pkg::KIND_RESET_Q, 0, 0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(dles_pkg::CFG_INCREMENT, 8);
                    write_reg(dles_pkg::CFG_VDELAY, 1);
                end
                1:
                begin
                    write_reg(dles_pkg::CFG_INCREMENT, 1);
                    write_reg(dles_pkg::CFG_VDELAY, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(dles_pkg::CFG_INCREMENT, 15);
                    write_reg(dles_pkg::CFG_VDELAY, 0);
                end
                default:
                begin
                    write_reg(dles_pkg::CFG_INCREMENT, $urandom_range(1, 8));
                    write_reg(dles_pkg::CFG_VDELAY, $urandom);
                end
            endcase
            send_op(dles_pkg::KIND_RESET_Q, 0, 0);
            send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? 65 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 65 : (phase % 4 == 3) ? 13 : 0;
            if (phase % 4 == 3)
            begin
                send_idle_pct = 13;
            end
            // Long hold-off on the result side while items keep coming
            if (phase == 4) hold_cycles = 400;
            for (int n = 0; n < 135; n++) random_item();
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
